>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/nfpe_pkg.sv
// ----------------------------------------------------------------------------
// nfpe_pkg
// Types and constants of the packed 4-bit frame store pixel engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfpe_pkg;

  localparam int FRAME_BYTES = 8192;
  localparam int MAX_DIM     = 128;

  localparam int FRAME_AW = $clog2(FRAME_BYTES);
  localparam int POS_W    = 16;
  localparam int DIM_W    = 8;
  localparam int CRD_W    = $clog2(MAX_DIM);
  localparam int PROD_W   = CRD_W + DIM_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int IDX_W    = SUM_W - 1;

  localparam logic [DIM_W-1:0] DIM_RST = 8'd128;
  localparam logic [3:0]       NIB_LO  = 4'hF;
  localparam logic [7:0]       BYTE_CLR = 8'h00;

  typedef enum logic [1:0] {
    CMD_BLACK  = 2'd0,
    CMD_WHITE  = 2'd1,
    CMD_INVERT = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MOD
  } state_t;

endpackage

>>> design/nibble_framebuffer_pixel_engine.sv
// ----------------------------------------------------------------------------
// nibble_framebuffer_pixel_engine
// Grayscale frame store, two 4-bit pixels per byte, with black, white,
// invert and read commands on signed pixel coordinates.
// ----------------------------------------------------------------------------
//
//   channel  handshake          payload
//   in       in_valid/in_ready  in_cmd, in_pos_x, in_pos_y
//   out      out_valid/out_ready out_lit (read commands only)
//   cfg      cfg_we             cfg_idx, cfg_data
//
// Each item passes S_READ, which forms the byte address and reads the frame
// memory, then S_MOD, which merges the nibble and writes it back; the next item is
// accepted in the write-back cycle.
// After reset a clearing pass writes zero to all FRAME_BYTES entries;
// no item is accepted meanwhile.
// A read result waits in the output register; a following read holds in
// write-back until that register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nibble_framebuffer_pixel_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_cmd,
  input  logic signed [nfpe_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [nfpe_pkg::POS_W-1:0] in_pos_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_lit,
  input  logic                           cfg_we,
  input  logic                           cfg_idx,
  input  logic [nfpe_pkg::DIM_W-1:0]     cfg_data
);
  import nfpe_pkg::*;

  localparam logic [POS_W-1:0] MAX_DIM_P = POS_W'(MAX_DIM);
  localparam logic [31:0]      FB_LIM    = 32'(FRAME_BYTES);

  state_t               state_r, state_nxt;
  logic [FRAME_AW-1:0]  clr_cnt_r;
  logic [DIM_W-1:0]     width_r, height_r;

  cmd_t                 cmd_r;
  logic [POS_W-1:0]     x_r, y_r;
  logic                 ok_r;
  logic [FRAME_AW-1:0]  addr_r;

  logic [7:0]           mem [FRAME_BYTES];
  logic [7:0]           rd_data_r;
  logic                 mem_we, mem_re;
  logic [FRAME_AW-1:0]  mem_waddr;
  logic [7:0]           mem_wdata;

  logic                 out_valid_r, out_lit_r;

  logic                 accept, out_free, mod_done, out_load;
  logic [POS_W-1:0]     w_eff, h_eff;
  logic                 x_ok, y_ok, idx_ok;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     sum;
  logic [IDX_W-1:0]     idx_full;
  logic                 high;
  logic [3:0]           old_nib, gray;

  // ---------------- address formation (S_READ) ----------------
  always_comb begin
    w_eff  = ({8'd0, width_r} > MAX_DIM_P) ? MAX_DIM_P : {8'd0, width_r};
    h_eff  = ({8'd0, height_r} > MAX_DIM_P) ? MAX_DIM_P : {8'd0, height_r};
    x_ok   = !x_r[POS_W-1] && ({1'b0, x_r[POS_W-2:0]} < w_eff);
    y_ok   = !y_r[POS_W-1] && ({1'b0, y_r[POS_W-2:0]} < h_eff);
    // in range, y and x fit CRD_W bits
    prod     = y_r[CRD_W-1:0] * width_r;
    sum      = {1'b0, prod} + SUM_W'(x_r[CRD_W-1:0]);
    idx_full = sum[SUM_W-1:1];
    idx_ok   = 32'(idx_full) < FB_LIM;
  end

  // ---------------- nibble merge (S_MOD) ----------------
  always_comb begin
    high    = !x_r[0];
    old_nib = high ? rd_data_r[7:4] : rd_data_r[3:0];
    case (cmd_r)
      CMD_BLACK:  gray = 4'd0;
      CMD_WHITE:  gray = NIB_LO;
      default:    gray = NIB_LO - old_nib;
    endcase
  end

  // ---------------- control ----------------
  assign out_free = !out_valid_r || out_ready;
  assign mod_done = (cmd_r != CMD_READ) || out_free;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_MOD) && mod_done);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_MOD) && (cmd_r == CMD_READ) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (&clr_cnt_r) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_READ;
      S_READ:  state_nxt = S_MOD;
      S_MOD: begin
        if (mod_done) state_nxt = accept ? S_READ : S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    mem_re    = (state_r == S_READ);
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = high ? {gray, rd_data_r[3:0]} : {rd_data_r[7:4], gray};
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = BYTE_CLR;
      end
      S_MOD:   mem_we = ok_r && (cmd_r != CMD_READ);
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      width_r     <= DIM_RST;
      height_r    <= DIM_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_idx))
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          default:    width_r  <= width_r;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
    end
    if (state_r == S_READ) begin
      ok_r   <= x_ok && y_ok && idx_ok;
      addr_r <= FRAME_AW'(idx_full);
    end
    if (out_load) out_lit_r <= ok_r && (old_nib != 4'd0);
  end

  // frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[FRAME_AW'(idx_full)];
  end

  assign out_valid = out_valid_r;
  assign out_lit   = out_lit_r;

  // ---------------- assertions ----------------
  `ASSERT_IMPLIES(a_no_accept_clear, clk, rst_n, state_r == S_CLEAR, !in_ready)
  `ASSERT_NEXT(a_accept_reads, clk, rst_n, accept, state_r == S_READ)
  `ASSERT_NEXT(a_read_then_mod, clk, rst_n, state_r == S_READ, state_r == S_MOD)
  `ASSERT_IMPLIES(a_we_state, clk, rst_n, mem_we,
                  (state_r == S_CLEAR) || (state_r == S_MOD))
  `ASSERT_IMPLIES(a_load_is_read, clk, rst_n, out_load, cmd_r == CMD_READ)

endmodule
